>>> rtl/core/anchor_record_decoder_checker_macros.svh
// Assertion macros shared by the record decoder RTL.
`ifndef ANCHOR_RECORD_DECODER_CHECKER_MACROS_SVH
`define ANCHOR_RECORD_DECODER_CHECKER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on i_clk, off during reset.
`define ARDC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, sampled on i_clk, off during reset.
`define ARDC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ARDC_ASSERT_IMP(lbl, ante, cons, msg)
`define ARDC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/core/ardc_pkg.sv
// Shared types, constants and the CRC-32 byte step for the record decoder.
`timescale 1ns / 1ps
`default_nettype none

package ardc_pkg;

    // Record layout
    localparam int unsigned HDR_BYTES = 20;
    localparam int unsigned CRC_SPAN  = 16;

    // CRC-32, reflected
    localparam logic [31:0] CRC_POLY = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 2'd1;

    // Result kinds
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Depth of the queue between front and back
    localparam int unsigned Q_DEPTH = 4;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_SIZE = 2'd1,
        ST_BAD  = 2'd2
    } t_status;

    // One command per input byte that causes any result
    typedef struct packed {
        logic        has_pay;
        logic        has_sum;
        logic [7:0]  pay_value;
        logic [5:0]  pay_index;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] size;
        logic [63:0] sequence_no;
        logic [31:0] checksum;
        t_status     status;
    } t_cmd;

    // Eight bit steps of the reflected CRC over one byte
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                               input logic [7:0]  b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/ardc_front.sv
// Front end: byte position, header capture, running CRC and command build.
`timescale 1ns / 1ps
`default_nettype none
`include "anchor_record_decoder_checker_macros.svh"

module ardc_front #(
    parameter int unsigned PAYLOAD_MAX = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [ardc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                    i_cfg_data,
    input  wire logic                           i_accept,
    input  wire logic [7:0]                     i_image_byte,
    output logic                                o_cmd_valid,
    output ardc_pkg::t_cmd                      o_cmd
);
    import ardc_pkg::*;

    localparam int unsigned IMAGE_BYTES = HDR_BYTES + PAYLOAD_MAX;
    localparam int unsigned POS_W       = $clog2(IMAGE_BYTES);
    localparam logic [POS_W-1:0] POS_HDR  = POS_W'(HDR_BYTES);
    localparam logic [POS_W-1:0] POS_SPAN = POS_W'(CRC_SPAN);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(IMAGE_BYTES - 1);
    localparam logic [15:0]      MAX16    = 16'(PAYLOAD_MAX);

    logic [31:0]      r_exp_magic;
    logic [15:0]      r_exp_version;
    logic [POS_W-1:0] r_pos, n_pos;
    logic [31:0]      r_crc, n_crc;
    logic [31:0]      r_magic;
    logic [15:0]      r_version;
    logic [15:0]      r_size;
    logic [63:0]      r_seq;
    logic [31:0]      r_chk;

    logic [POS_W-1:0] idx;
    logic             in_hdr;
    logic             size_ok;
    logic             has_pay;
    logic             is_last;
    logic             crc_upd;
    logic [31:0]      crc_after;
    t_status          status;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_magic   <= '0;
            r_exp_version <= '0;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_MAGIC:   r_exp_magic   <= i_cfg_data;
                CFG_VERSION: r_exp_version <= i_cfg_data[15:0];
                default:     ;
            endcase
        end
    end

    // Classify the current byte
    always_comb begin
        idx       = r_pos - POS_HDR;
        in_hdr    = r_pos < POS_HDR;
        size_ok   = r_size <= MAX16;
        has_pay   = !in_hdr && size_ok && (16'(idx) < r_size);
        is_last   = r_pos == POS_LAST;
        crc_upd   = (r_pos < POS_SPAN) || has_pay;
        crc_after = crc_upd ? crc32_byte(r_crc, i_image_byte) : r_crc;
        if (!size_ok) begin
            status = ST_SIZE;
        end else if (r_magic != r_exp_magic || r_version != r_exp_version ||
                     ~crc_after != r_chk) begin
            status = ST_BAD;
        end else begin
            status = ST_OK;
        end
        n_pos = is_last ? '0 : r_pos + POS_W'(1);
        n_crc = is_last ? CRC_INIT : crc_after;
    end

    // Position and CRC
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= '0;
            r_crc <= CRC_INIT;
        end else if (i_accept) begin
            r_pos <= n_pos;
            r_crc <= n_crc;
        end
    end

    // Header capture, one lane per byte
    always_ff @(posedge i_clk) begin
        if (i_accept && in_hdr) begin
            if (r_pos < POS_W'(4)) begin
                r_magic[r_pos[1:0]*8 +: 8] <= i_image_byte;
            end else if (r_pos < POS_W'(6)) begin
                r_version[r_pos[0]*8 +: 8] <= i_image_byte;
            end else if (r_pos < POS_W'(8)) begin
                r_size[r_pos[0]*8 +: 8] <= i_image_byte;
            end else if (r_pos < POS_SPAN) begin
                r_seq[r_pos[2:0]*8 +: 8] <= i_image_byte;
            end else begin
                r_chk[r_pos[1:0]*8 +: 8] <= i_image_byte;
            end
        end
    end

    // Command toward the queue
    always_comb begin
        o_cmd_valid       = i_accept && (has_pay || is_last);
        o_cmd.has_pay     = has_pay;
        o_cmd.has_sum     = is_last;
        o_cmd.pay_value   = i_image_byte;
        o_cmd.pay_index   = 6'(idx);
        o_cmd.magic       = r_magic;
        o_cmd.version     = r_version;
        o_cmd.size        = r_size;
        o_cmd.sequence_no = r_seq;
        o_cmd.checksum    = r_chk;
        o_cmd.status      = status;
    end

    `ARDC_ASSERT_NXT(a_fr_wrap, i_accept && is_last, r_pos == '0 && r_crc == CRC_INIT, "position did not re-arm after last byte")

endmodule

`default_nettype wire

>>> rtl/core/ardc_queue.sv
// Small command queue that decouples the front end from the result side.
`timescale 1ns / 1ps
`default_nettype none
`include "anchor_record_decoder_checker_macros.svh"

module ardc_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire ardc_pkg::t_cmd i_cmd,
    input  wire logic           i_rd,
    output logic                o_full,
    output logic                o_valid,
    output ardc_pkg::t_cmd      o_head
);
    import ardc_pkg::*;

    localparam int unsigned PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned CNT_W = PTR_W + 1;
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(Q_DEPTH);

    t_cmd             r_mem [Q_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = r_count == CNT_FULL;
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];

    // Occupancy
    always_comb begin
        n_count = r_count;
        if (i_wr && !i_rd) begin
            n_count = r_count + CNT_W'(1);
        end else if (!i_wr && i_rd) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    // Pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= n_count;
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    `ARDC_ASSERT_IMP(a_q_no_ovf, i_wr, !o_full || i_rd, "write into a full queue")
    `ARDC_ASSERT_IMP(a_q_no_unf, i_rd, o_valid, "read from an empty queue")

endmodule

`default_nettype wire

>>> rtl/core/ardc_back.sv
// Back end: expands each queued command into one or two result beats.
`timescale 1ns / 1ps
`default_nettype none
`include "anchor_record_decoder_checker_macros.svh"

module ardc_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire ardc_pkg::t_cmd i_head,
    input  wire logic           i_pop,
    output logic                o_deq,
    output logic                o_empty,
    output logic                o_item_kind,
    output logic [7:0]          o_payload_value,
    output logic [5:0]          o_payload_index,
    output logic [31:0]         o_magic_read,
    output logic [15:0]         o_version_read,
    output logic [15:0]         o_size_read,
    output logic [63:0]         o_sequence_number,
    output logic [31:0]         o_stored_checksum,
    output logic [1:0]          o_status,
    output logic                o_last_of_run
);
    import ardc_pkg::*;

    // Set once the payload beat of a two-beat command has gone out
    logic r_pay_done;
    logic show_pay;
    logic take;

    assign o_empty  = !i_valid;
    assign show_pay = i_head.has_pay && !r_pay_done;
    assign take     = i_valid && i_pop;
    assign o_deq    = take && !(show_pay && i_head.has_sum);

    // Result beat
    always_comb begin
        if (show_pay) begin
            o_item_kind       = KIND_PAYLOAD;
            o_payload_value   = i_head.pay_value;
            o_payload_index   = i_head.pay_index;
            o_magic_read      = '0;
            o_version_read    = '0;
            o_size_read       = '0;
            o_sequence_number = '0;
            o_stored_checksum = '0;
            o_status          = ST_OK;
            o_last_of_run     = !i_head.has_sum;
        end else begin
            o_item_kind       = KIND_SUMMARY;
            o_payload_value   = '0;
            o_payload_index   = '0;
            o_magic_read      = i_head.magic;
            o_version_read    = i_head.version;
            o_size_read       = i_head.size;
            o_sequence_number = i_head.sequence_no;
            o_stored_checksum = i_head.checksum;
            o_status          = i_head.status;
            o_last_of_run     = 1'b1;
        end
    end

    // Beat tracking within a command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pay_done <= 1'b0;
        end else if (take) begin
            r_pay_done <= !o_deq;
        end
    end

    `ARDC_ASSERT_IMP(a_bk_phase, r_pay_done, i_valid && i_head.has_pay && i_head.has_sum, "payload-done flag without a two-beat command")

endmodule

`default_nettype wire

>>> rtl/core/anchor_record_decoder_checker.sv
// Top level of the CRC-checked record decoder: front end, command queue, back end.
//
//  channel   | direction | handshake            | beat
//  ----------+-----------+----------------------+--------------------------------------
//  config    | in        | i_cfg_wr_en          | i_cfg_index, i_cfg_data
//  image     | in        | push / full          | i_image_byte
//  result    | out       | empty / pop          | o_item_kind .. o_last_of_run
//
// One image byte is taken per cycle while full is low; header parse and the unrolled CRC byte step fit in that cycle.
// A byte that causes results enters a four-entry queue the cycle it is taken.
// The result side shows one beat per cycle while pop is high, from the cycle after the byte is taken. The last
// byte gives two beats when the size fills the payload area; that extra beat drains during
// the next header, so with pop held high full never rises.
// full rises only when the queue holds four commands. Reset is synchronous, active low.
`timescale 1ns / 1ps
`default_nettype none

module anchor_record_decoder_checker #(
    parameter int unsigned PAYLOAD_MAX = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  i_image_byte,
    output logic             empty,
    input  wire logic        pop,
    output logic             o_item_kind,
    output logic [7:0]       o_payload_value,
    output logic [5:0]       o_payload_index,
    output logic [31:0]      o_magic_read,
    output logic [15:0]      o_version_read,
    output logic [15:0]      o_size_read,
    output logic [63:0]      o_sequence_number,
    output logic [31:0]      o_stored_checksum,
    output logic [1:0]       o_status,
    output logic             o_last_of_run
);
    import ardc_pkg::*;

    logic accept;
    logic cmd_valid;
    t_cmd cmd;
    logic q_valid;
    t_cmd q_head;
    logic q_deq;

    assign accept = push && !full;

    // Parse and classify
    ardc_front #(
        .PAYLOAD_MAX (PAYLOAD_MAX)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_wr_en  (i_cfg_wr_en),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_accept     (accept),
        .i_image_byte (i_image_byte),
        .o_cmd_valid  (cmd_valid),
        .o_cmd        (cmd)
    );

    // Decoupling queue
    ardc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (cmd_valid),
        .i_cmd   (cmd),
        .i_rd    (q_deq),
        .o_full  (full),
        .o_valid (q_valid),
        .o_head  (q_head)
    );

    // Result beats
    ardc_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (q_valid),
        .i_head            (q_head),
        .i_pop             (pop),
        .o_deq             (q_deq),
        .o_empty           (empty),
        .o_item_kind       (o_item_kind),
        .o_payload_value   (o_payload_value),
        .o_payload_index   (o_payload_index),
        .o_magic_read      (o_magic_read),
        .o_version_read    (o_version_read),
        .o_size_read       (o_size_read),
        .o_sequence_number (o_sequence_number),
        .o_stored_checksum (o_stored_checksum),
        .o_status          (o_status),
        .o_last_of_run     (o_last_of_run)
    );

endmodule

`default_nettype wire

>>> tb/anchor_record_decoder_checker_tb.sv
// Self-checking testbench for the CRC-checked record decoder: directed records, then random ones.
`timescale 1ns / 1ps

module anchor_record_decoder_checker_tb;
    import ardc_pkg::*;

    localparam int unsigned PAYLOAD_MAX   = 64;
    localparam int unsigned REC_BYTES     = HDR_BYTES + PAYLOAD_MAX;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned CYCLE_LIMIT   = 200000;
    localparam int unsigned PRINT_CAP     = 50;

    // Register indexes the block does not implement
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

    // One expected result beat
    typedef struct packed {
        logic        kind;
        logic [7:0]  value;
        logic [5:0]  index;
        logic [31:0] magic;
        logic [15:0] version;
        logic [15:0] size;
        logic [63:0] seq_no;
        logic [31:0] checksum;
        t_status     status;
        logic        last;
    } t_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;
    logic        push;
    logic        full;
    logic [7:0]  i_image_byte;
    logic        empty;
    logic        pop;
    logic        o_item_kind;
    logic [7:0]  o_payload_value;
    logic [5:0]  o_payload_index;
    logic [31:0] o_magic_read;
    logic [15:0] o_version_read;
    logic [15:0] o_size_read;
    logic [63:0] o_sequence_number;
    logic [31:0] o_stored_checksum;
    logic [1:0]  o_status;
    logic        o_last_of_run;

    anchor_record_decoder_checker #(
        .PAYLOAD_MAX(PAYLOAD_MAX)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .push             (push),
        .full             (full),
        .i_image_byte     (i_image_byte),
        .empty            (empty),
        .pop              (pop),
        .o_item_kind      (o_item_kind),
        .o_payload_value  (o_payload_value),
        .o_payload_index  (o_payload_index),
        .o_magic_read     (o_magic_read),
        .o_version_read   (o_version_read),
        .o_size_read      (o_size_read),
        .o_sequence_number(o_sequence_number),
        .o_stored_checksum(o_stored_checksum),
        .o_status         (o_status),
        .o_last_of_run    (o_last_of_run)
    );

    // Decoder shadow state and register copies
    logic [31:0] want_magic;
    logic [15:0] want_version;
    int unsigned rec_pos;
    logic [31:0] hdr_magic;
    logic [15:0] hdr_version;
    logic [15:0] hdr_size;
    logic [63:0] hdr_seq;
    logic [31:0] hdr_checksum;
    logic [31:0] rec_crc;

    t_beat       pending_beats[$];
    t_beat       want;

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned bytes_sent;
    int unsigned records_sent;
    int unsigned payload_beats;
    int unsigned summary_beats;
    int unsigned status_hits[3];
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side backpressure
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            pop = ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Reflected CRC-32, one data bit at a time, LSB first
    function automatic logic [31:0] crc_step(input logic [31:0] acc, input logic [7:0] data);
        logic [31:0] v;
        v = acc;
        for (int k = 0; k < 8; k++) begin
            if (v[0] ^ data[k]) v = (v >> 1) ^ CRC_POLY;
            else                v = v >> 1;
        end
        return v;
    endfunction

    // Advance the decoder shadow by one accepted image byte and queue its beats
    function automatic void decode_byte(input logic [7:0] b);
        t_beat       pay;
        t_beat       summ;
        logic        have_pay;
        logic        have_sum;
        int unsigned idx;
        pay = '0;
        summ = '0;
        have_pay = 1'b0;
        have_sum = 1'b0;
        if (rec_pos < HDR_BYTES) begin
            if (rec_pos < CRC_SPAN) rec_crc = crc_step(rec_crc, b);
            if (rec_pos < 4)       hdr_magic[8*rec_pos +: 8] = b;
            else if (rec_pos < 6)  hdr_version[8*(rec_pos-4) +: 8] = b;
            else if (rec_pos < 8)  hdr_size[8*(rec_pos-6) +: 8] = b;
            else if (rec_pos < 16) hdr_seq[8*(rec_pos-8) +: 8] = b;
            else                   hdr_checksum[8*(rec_pos-16) +: 8] = b;
        end else begin
            idx = rec_pos - HDR_BYTES;
            // only bytes inside an in-range size are emitted and checksummed
            if (hdr_size <= PAYLOAD_MAX && idx < hdr_size) begin
                rec_crc = crc_step(rec_crc, b);
                pay.kind = KIND_PAYLOAD;
                pay.value = b;
                pay.index = idx[5:0];
                have_pay = 1'b1;
            end
        end
        if (rec_pos == REC_BYTES - 1) begin
            summ.kind = KIND_SUMMARY;
            summ.magic = hdr_magic;
            summ.version = hdr_version;
            summ.size = hdr_size;
            summ.seq_no = hdr_seq;
            summ.checksum = hdr_checksum;
            // size check wins over magic, version and CRC
            if (hdr_size > PAYLOAD_MAX) summ.status = ST_SIZE;
            else if (hdr_magic != want_magic || hdr_version != want_version ||
                     ~rec_crc != hdr_checksum) summ.status = ST_BAD;
            else summ.status = ST_OK;
            status_hits[summ.status]++;
            have_sum = 1'b1;
            rec_pos = 0;
            rec_crc = CRC_INIT;
        end else begin
            rec_pos++;
        end
        if (have_sum) begin
            summ.last = 1'b1;
            if (have_pay) pending_beats.push_back(pay);
            pending_beats.push_back(summ);
        end else if (have_pay) begin
            pay.last = 1'b1;
            pending_beats.push_back(pay);
        end
        bytes_sent++;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp_val);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch at beat %0d: %s got %0h want %0h",
                     payload_beats + summary_beats, what, got, exp_val);
        mismatch_count++;
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_beats.size() == 0) begin
                report_mismatch("unexpected beat, kind", o_item_kind, 0);
            end else begin
                want = pending_beats.pop_front();
                if (o_item_kind !== want.kind)
                    report_mismatch("item_kind", o_item_kind, want.kind);
                if (o_payload_value !== want.value)
                    report_mismatch("payload_value", o_payload_value, want.value);
                if (o_payload_index !== want.index)
                    report_mismatch("payload_index", o_payload_index, want.index);
                if (o_magic_read !== want.magic)
                    report_mismatch("magic_read", o_magic_read, want.magic);
                if (o_version_read !== want.version)
                    report_mismatch("version_read", o_version_read, want.version);
                if (o_size_read !== want.size)
                    report_mismatch("size_read", o_size_read, want.size);
                if (o_sequence_number !== want.seq_no)
                    report_mismatch("sequence_number", o_sequence_number, want.seq_no);
                if (o_stored_checksum !== want.checksum)
                    report_mismatch("stored_checksum", o_stored_checksum, want.checksum);
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_last_of_run !== want.last)
                    report_mismatch("last_of_run", o_last_of_run, want.last);
            end
            if (o_item_kind === KIND_SUMMARY) summary_beats++;
            else                              payload_beats++;
        end
    end

    // Send one image byte; returns once the beat is taken
    task automatic send_byte(input logic [7:0] b);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            push = 1'b0;
            @(negedge i_clk);
        end
        push = 1'b1;
        i_image_byte = b;
        do @(posedge i_clk); while (full);
        decode_byte(b);
    endtask

    // Hold off the sender until every queued beat has come out
    task automatic wait_drained();
        @(negedge i_clk);
        push = 1'b0;
        while (pending_beats.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        wait_drained();
        @(negedge i_clk);
        i_cfg_wr_en = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        case (idx)
            CFG_MAGIC:   want_magic = data;
            CFG_VERSION: want_version = data[15:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_wr_en = 1'b0;
        i_cfg_data = $urandom;
    endtask

    // Build one full image with random payload; flip corrupts the stored CRC
    task automatic send_record(input logic [31:0] magic, input logic [15:0] version,
                               input logic [15:0] size, input logic [63:0] seq_no,
                               input logic [31:0] flip);
        logic [7:0]  img [REC_BYTES];
        logic [31:0] c;
        int          pause_at;
        for (int i = 0; i < 4; i++) img[i] = magic[8*i +: 8];
        for (int i = 0; i < 2; i++) img[4+i] = version[8*i +: 8];
        for (int i = 0; i < 2; i++) img[6+i] = size[8*i +: 8];
        for (int i = 0; i < 8; i++) img[8+i] = seq_no[8*i +: 8];
        for (int i = HDR_BYTES; i < REC_BYTES; i++) img[i] = $urandom;
        c = CRC_INIT;
        for (int i = 0; i < CRC_SPAN; i++) c = crc_step(c, img[i]);
        if (size <= PAYLOAD_MAX)
            for (int i = 0; i < size; i++) c = crc_step(c, img[HDR_BYTES+i]);
        c = ~c ^ flip;
        for (int i = 0; i < 4; i++) img[16+i] = c[8*i +: 8];
        // now and then stall mid-record until the block has drained
        pause_at = ($urandom_range(7) == 0) ? int'($urandom_range(REC_BYTES - 1)) : -1;
        for (int i = 0; i < REC_BYTES; i++) begin
            if (i == pause_at) wait_drained();
            send_byte(img[i]);
        end
        records_sent++;
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(3))
            0:       return 32'h0;
            1:       return 32'hFFFFFFFF;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Registers at reset value: zero magic and version must pass
    task automatic test_reset_defaults();
        send_record(32'h0, 16'h0, 16'd0, 64'hFFFFFFFFFFFFFFFF, 32'h0);
    endtask

    // All-ones registers, full payload so the last byte gives two beats
    task automatic test_full_payload();
        write_reg(CFG_MAGIC, 32'hFFFFFFFF);
        write_reg(CFG_VERSION, 32'h0000FFFF);
        send_record(want_magic, want_version, 16'(PAYLOAD_MAX), 64'h0, 32'h0);
    endtask

    // Short sizes: trailing payload bytes give nothing and skip the CRC
    task automatic test_short_sizes();
        write_reg(CFG_MAGIC, 32'hA5C3_0F1E);
        write_reg(CFG_VERSION, 32'hFFFF_0102);
        send_record(want_magic, want_version, 16'd1, rand64(), 32'h0);
        send_record(want_magic, want_version, 16'd20, rand64(), 32'h0);
        send_record(want_magic, want_version, 16'd63, rand64(), 32'h0);
    endtask

    // Oversize: no payload beats, size status beats every other error
    task automatic test_oversize();
        send_record(want_magic, want_version, 16'(PAYLOAD_MAX + 1), rand64(), 32'h0);
        send_record(~want_magic, ~want_version, 16'hFFFF, rand64(), 32'h8000_0001);
    endtask

    // Bad magic, version or CRC with a legal size still emits payload
    task automatic test_bad_fields();
        send_record(want_magic ^ 32'h8000_0000, want_version, 16'd10, rand64(), 32'h0);
        send_record(want_magic, want_version ^ 16'h0001, 16'd5, rand64(), 32'h0);
        send_record(want_magic, want_version, 16'd33, rand64(), 32'h0001_0000);
    endtask

    // Writes to unused indexes leave both registers alone
    task automatic test_spare_indexes();
        write_reg(CFG_SPARE_LO, 32'hFFFFFFFF);
        write_reg(CFG_SPARE_HI, $urandom);
        send_record(want_magic, want_version, 16'd7, rand64(), 32'h0);
    endtask

    // Mostly well-formed records with random content, plus broken ones and noise
    task automatic test_random_records(input int unsigned count);
        int unsigned pick;
        logic [15:0] sz;
        repeat (count) begin
            if ($urandom_range(3) == 0) begin
                write_reg(CFG_MAGIC, pick_word());
                write_reg(CFG_VERSION, pick_word());
            end
            pick = $urandom_range(99);
            sz = 16'($urandom_range(PAYLOAD_MAX));
            if (pick < 60)
                send_record(want_magic, want_version, sz, rand64(), 32'h0);
            else if (pick < 68)
                send_record(want_magic ^ (32'h1 << $urandom_range(31)), want_version, sz,
                            rand64(), 32'h0);
            else if (pick < 76)
                send_record(want_magic, want_version ^ (16'h1 << $urandom_range(15)), sz,
                            rand64(), 32'h0);
            else if (pick < 84)
                send_record(want_magic, want_version, sz, rand64(),
                            32'h1 << $urandom_range(31));
            else if (pick < 92)
                send_record(want_magic, want_version,
                            16'($urandom_range(65535, PAYLOAD_MAX + 1)), rand64(), 32'h0);
            else
                send_record($urandom, 16'($urandom), 16'($urandom), rand64(), $urandom);
        end
    endtask

    // Main sequence
    initial begin
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_index = CFG_MAGIC;
        i_cfg_data = 32'h0;
        push = 1'b0;
        i_image_byte = 8'h0;
        want_magic = 32'h0;
        want_version = 16'h0;
        rec_pos = 0;
        hdr_magic = 32'h0;
        hdr_version = 16'h0;
        hdr_size = 16'h0;
        hdr_seq = 64'h0;
        hdr_checksum = 32'h0;
        rec_crc = CRC_INIT;
        mismatch_count = 0;
        bytes_sent = 0;
        records_sent = 0;
        payload_beats = 0;
        summary_beats = 0;
        status_hits = '{0, 0, 0};
        send_idle_pct = 18;
        recv_idle_pct = 62;

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_defaults();
        test_full_payload();
        test_short_sizes();
        test_oversize();
        test_bad_fields();
        test_spare_indexes();

        test_random_records(3);
        send_idle_pct = 62;
        recv_idle_pct = 18;
        test_random_records(3);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_records(3);

        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("Sent %0d records (%0d image bytes); checked %0d payload and %0d summary beats",
                 records_sent, bytes_sent, payload_beats, summary_beats);
        $display("Summary status mix: %0d ok, %0d oversize, %0d bad header or CRC",
                 status_hits[ST_OK], status_hits[ST_SIZE], status_hits[ST_BAD]);
        if (mismatch_count == 0 && pending_beats.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/ardc_pkg.sv
rtl/core/ardc_front.sv
rtl/core/ardc_queue.sv
rtl/core/ardc_back.sv
rtl/core/anchor_record_decoder_checker.sv
tb/anchor_record_decoder_checker_tb.sv
